[rtl/core/wsd_pkg.sv]
package wsd_pkg;

  localparam int unsigned LengthBitsDefault = 64;
  localparam logic [15:0] MaxFrameReset = 16'd512;

  localparam logic [3:0] OpContinuation = 4'h0;
  localparam logic [3:0] OpText = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpcodeMask = 4'hF;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic [3:0] ExtCount16 = 4'd2;
  localparam logic [3:0] ExtCount64 = 4'd8;
  localparam logic [3:0] KeyCount = 4'd4;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindReply = 2'd2;

  localparam logic [7:0] ReplyCloseHdr = 8'h88;
  localparam logic [7:0] ReplyLenZero = 8'h00;
  localparam logic [7:0] ReplyLenTwo = 8'h02;
  localparam logic [7:0] ReplyCodeHi = 8'h03;
  localparam logic [7:0] ReplyCodeLo = 8'hF1;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt,
    PhKey,
    PhPayload,
    PhDrain,
    PhClosed
  } phase_e;

  // What one received byte causes on the result side.
  typedef enum logic [2:0] {
    EmNone,
    EmPayload,
    EmDone,
    EmClose,
    EmTooBig
  } emit_e;

  typedef struct packed {
    emit_e      kind;
    logic [7:0] data;
    logic       opcode;
    logic       last;
  } emit_t;

  function automatic logic [7:0] reply_byte(input emit_e kind, input logic [1:0] beat);
    logic [7:0] r;
    r = ReplyCloseHdr;
    if (kind == EmClose) begin
      r = (beat == 2'd0) ? ReplyCloseHdr : ReplyLenZero;
    end else begin
      case (beat)
        2'd0:    r = ReplyCloseHdr;
        2'd1:    r = ReplyLenTwo;
        2'd2:    r = ReplyCodeHi;
        2'd3:    r = ReplyCodeLo;
        default: r = ReplyCloseHdr;
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/core/websocket_frame_deframer.sv]
// Client-to-server frame deframer. Received bytes go in one beat at a time on rx_*, and
// the block takes a new byte in every cycle while results flow freely: each byte is parsed
// in the cycle it is accepted and its results land in an output register. A payload byte
// gives one result beat, so the sustained rate is one byte per cycle. A close reply fills
// the output register for two beats and an oversized-frame reply for four, since the output
// register sends one reply byte per beat; the input waits until the last of those beats is
// taken. After either reply the block is closed and drops all bytes until reset. The user must
// write max_frame through cfg_we_i/cfg_wdata_i only while idle; the block does not check it.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_opcode_o,
  output logic        last_o
);

  logic [15:0]    max_frame_q;
  wsd_pkg::emit_t emit;
  wsd_pkg::emit_t res_q;
  logic           res_valid_q;
  logic [1:0]     beat_q;
  logic           final_beat;
  logic           rx_fire;
  logic           out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= wsd_pkg::MaxFrameReset;
    end else if (cfg_we_i) begin
      max_frame_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    case (res_q.kind)
      wsd_pkg::EmClose:  final_beat = (beat_q == 2'd1);
      wsd_pkg::EmTooBig: final_beat = (beat_q == 2'd3);
      default:           final_beat = 1'b1;
    endcase
  end

  assign out_fire = res_valid_q && out_ready_i;
  assign rx_ready_o = !res_valid_q || (out_ready_i && final_beat);
  assign rx_fire = rx_valid_i && rx_ready_o;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (rx_fire),
    .rx_byte_i  (rx_byte_i),
    .max_frame_i(max_frame_q),
    .emit_o     (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      if (rx_fire && (emit.kind != wsd_pkg::EmNone)) begin
        res_valid_q <= 1'b1;
        beat_q      <= '0;
      end else if (out_fire) begin
        if (final_beat) begin
          res_valid_q <= 1'b0;
        end else begin
          beat_q <= beat_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && (emit.kind != wsd_pkg::EmNone)) begin
      res_q <= emit;
    end
  end

  always_comb begin
    out_valid_o = res_valid_q;
    case (res_q.kind)
      wsd_pkg::EmPayload: begin
        out_kind_o     = wsd_pkg::KindPayload;
        out_byte_o     = res_q.data;
        frame_opcode_o = res_q.opcode;
        last_o         = res_q.last;
      end
      wsd_pkg::EmDone: begin
        out_kind_o     = wsd_pkg::KindDone;
        out_byte_o     = 8'h00;
        frame_opcode_o = res_q.opcode;
        last_o         = 1'b1;
      end
      default: begin
        out_kind_o     = wsd_pkg::KindReply;
        out_byte_o     = wsd_pkg::reply_byte(res_q.kind, beat_q);
        frame_opcode_o = 1'b0;
        last_o         = final_beat;
      end
    endcase
  end

  // A result that is held back must also hold back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !rx_ready_o)
    else $error("input accepted while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == wsd_pkg::KindDone)) |-> ((out_byte_o == 8'h00) && last_o))
    else $error("frame done beat malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_kind_o == wsd_pkg::KindPayload) || (out_kind_o == wsd_pkg::KindDone)
                     || ((out_kind_o == wsd_pkg::KindReply) && !frame_opcode_o)))
    else $error("bad result kind or reply opcode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (out_kind_o == wsd_pkg::KindReply) && last_o) |=> !out_valid_o)
    else $error("result after closing reply");

endmodule

[rtl/core/wsd_parser.sv]
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [15:0]       max_frame_i,
  output wsd_pkg::emit_t    emit_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_on_q, mask_on_d;
  logic [3:0]             hdr_cnt_q, hdr_cnt_d;
  logic [31:0]            key_q, key_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [1:0]             offset_q, offset_d;
  logic                   too_big_q, too_big_d;

  logic [6:0]             len7;
  logic                   len7_short;
  logic [LENGTH_BITS-1:0] ext_next;
  logic [LENGTH_BITS-1:0] len_fin;
  logic [LENGTH_BITS-1:0] left_dec;
  logic                   hdr_end;
  logic                   to_key;
  logic                   is_close;
  logic                   is_data;
  logic                   len_zero;
  logic                   len_big;
  logic                   drain_end;
  logic [7:0]             key_byte;

  assign len7 = rx_byte_i[6:0];
  assign len7_short = (len7 != wsd_pkg::Len16Code) && (len7 != wsd_pkg::Len64Code);

  // Extended length shifts in big-endian and pins at all ones once it would overflow.
  always_comb begin
    if (|left_q[LENGTH_BITS-1 -: 8]) begin
      ext_next = '1;
    end else begin
      ext_next = {left_q[LENGTH_BITS-9:0], rx_byte_i};
    end
  end

  assign hdr_end = ((phase_q == wsd_pkg::PhHdr1) && len7_short && !rx_byte_i[7])
                || ((phase_q == wsd_pkg::PhExt) && (hdr_cnt_q == 4'd1) && !mask_on_q)
                || ((phase_q == wsd_pkg::PhKey) && (hdr_cnt_q == 4'd1));
  assign to_key = ((phase_q == wsd_pkg::PhHdr1) && len7_short && rx_byte_i[7])
               || ((phase_q == wsd_pkg::PhExt) && (hdr_cnt_q == 4'd1) && mask_on_q);

  always_comb begin
    case (phase_q)
      wsd_pkg::PhHdr1: len_fin = LENGTH_BITS'(len7);
      wsd_pkg::PhExt:  len_fin = ext_next;
      default:         len_fin = left_q;
    endcase
  end

  assign is_close = (opcode_q == wsd_pkg::OpClose);
  assign is_data = (opcode_q == wsd_pkg::OpContinuation) || (opcode_q == wsd_pkg::OpText);
  assign len_zero = (len_fin == '0);
  assign len_big = (len_fin >= LENGTH_BITS'(max_frame_i));
  assign left_dec = left_q - LENGTH_BITS'(1);
  assign drain_end = (left_q == '0) || (left_dec == '0);

  always_comb begin
    case (offset_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      2'd3:    key_byte = key_q[7:0];
      default: key_byte = key_q[31:24];
    endcase
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      case (phase_q)
        wsd_pkg::PhHdr0: phase_d = wsd_pkg::PhHdr1;
        wsd_pkg::PhHdr1, wsd_pkg::PhExt, wsd_pkg::PhKey: begin
          if (to_key) begin
            phase_d = wsd_pkg::PhKey;
          end else if (hdr_end) begin
            if (is_close) begin
              phase_d = wsd_pkg::PhClosed;
            end else if (!is_data) begin
              phase_d = len_zero ? wsd_pkg::PhHdr0 : wsd_pkg::PhDrain;
            end else if (len_big) begin
              phase_d = len_zero ? wsd_pkg::PhClosed : wsd_pkg::PhDrain;
            end else if (len_zero) begin
              phase_d = wsd_pkg::PhHdr0;
            end else begin
              phase_d = wsd_pkg::PhPayload;
            end
          end else if (phase_q == wsd_pkg::PhHdr1) begin
            phase_d = wsd_pkg::PhExt;
          end
        end
        wsd_pkg::PhPayload: begin
          if (left_dec == '0) phase_d = wsd_pkg::PhHdr0;
        end
        wsd_pkg::PhDrain: begin
          if (drain_end) phase_d = too_big_q ? wsd_pkg::PhClosed : wsd_pkg::PhHdr0;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Datapath registers and the result descriptor.
  always_comb begin
    opcode_d = opcode_q;
    mask_on_d = mask_on_q;
    hdr_cnt_d = hdr_cnt_q;
    key_d = key_q;
    left_d = left_q;
    offset_d = offset_q;
    too_big_d = too_big_q;
    emit_o = '{kind: wsd_pkg::EmNone, data: 8'h00, opcode: opcode_q[0], last: 1'b0};
    if (fire_i) begin
      case (phase_q)
        wsd_pkg::PhHdr0: opcode_d = rx_byte_i[3:0] & wsd_pkg::OpcodeMask;
        wsd_pkg::PhHdr1: begin
          mask_on_d = rx_byte_i[7];
          key_d = '0;
          left_d = len7_short ? LENGTH_BITS'(len7) : '0;
          if (len7 == wsd_pkg::Len16Code) hdr_cnt_d = wsd_pkg::ExtCount16;
          if (len7 == wsd_pkg::Len64Code) hdr_cnt_d = wsd_pkg::ExtCount64;
        end
        wsd_pkg::PhExt: begin
          left_d = ext_next;
          hdr_cnt_d = hdr_cnt_q - 4'd1;
        end
        wsd_pkg::PhKey: begin
          key_d = {key_q[23:0], rx_byte_i};
          hdr_cnt_d = hdr_cnt_q - 4'd1;
        end
        wsd_pkg::PhPayload: begin
          left_d = left_dec;
          offset_d = offset_q + 2'd1;
          emit_o.kind = wsd_pkg::EmPayload;
          emit_o.data = rx_byte_i ^ key_byte;
          emit_o.last = (left_dec == '0);
        end
        wsd_pkg::PhDrain: begin
          if (left_q != '0) left_d = left_dec;
          if (drain_end && too_big_q) emit_o.kind = wsd_pkg::EmTooBig;
        end
        default: ;
      endcase
      if (to_key) begin
        hdr_cnt_d = wsd_pkg::KeyCount;
      end
      if (hdr_end) begin
        offset_d = 2'd0;
        too_big_d = is_data && !is_close && len_big;
        if (is_close) begin
          emit_o.kind = wsd_pkg::EmClose;
        end else if (is_data && len_big && len_zero) begin
          emit_o.kind = wsd_pkg::EmTooBig;
        end else if (is_data && !len_big && len_zero) begin
          emit_o.kind = wsd_pkg::EmDone;
          emit_o.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsd_pkg::PhHdr0;
      opcode_q  <= '0;
      mask_on_q <= 1'b0;
      hdr_cnt_q <= '0;
      key_q     <= '0;
      left_q    <= '0;
      offset_q  <= '0;
      too_big_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_on_q <= mask_on_d;
      hdr_cnt_q <= hdr_cnt_d;
      key_q     <= key_d;
      left_q    <= left_d;
      offset_q  <= offset_d;
      too_big_q <= too_big_d;
    end
  end

endmodule
